/* design/lrt_pkg.sv */
package lrt_pkg;

    localparam int LAYER_W  = 5;
    localparam int EXPERT_W = 6;
    localparam int ID_W     = LAYER_W + EXPERT_W;
    localparam int SLOTS    = 16;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 5;
    localparam int TOT_W    = 32;

    localparam logic [CNT_W-1:0] MAX_RESIDENT_RESET = CNT_W'(SLOTS);
    localparam logic [TOT_W-1:0] TOT_MAX            = {TOT_W{1'b1}};

    // command codes
    localparam logic CMD_ACCESS   = 1'b0;
    localparam logic CMD_PREFETCH = 1'b1;

    // status codes
    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_MISS     = 2'd1;
    localparam logic [1:0] ST_PREFETCH = 2'd2;
    localparam logic [1:0] ST_IGNORED  = 2'd3;

    // per-cell control from the sequencer
    typedef struct packed {
        logic valid;
        logic take_next;
        logic take_key;
    } cell_ctl_t;

endpackage

/* design/lrt_channels.sv */
interface lrt_req_if import lrt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [LAYER_W-1:0]  layer;
    logic [EXPERT_W-1:0] expert;

    modport source (output valid, command, layer, expert, input ready);
    modport sink   (input valid, command, layer, expert, output ready);
endinterface

interface lrt_rsp_if import lrt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [CNT_W-1:0]    evicted_count;
    logic [LAYER_W-1:0]  evicted_layer;
    logic [EXPERT_W-1:0] evicted_expert;
    logic [TOT_W-1:0]    hit_total;
    logic [TOT_W-1:0]    miss_total;
    logic [TOT_W-1:0]    eviction_total;
    logic [CNT_W-1:0]    resident_count;

    modport source (output valid, status, evicted_count, evicted_layer, evicted_expert,
                    hit_total, miss_total, eviction_total, resident_count,
                    input ready);
    modport sink   (input valid, status, evicted_count, evicted_layer, evicted_expert,
                    hit_total, miss_total, eviction_total, resident_count,
                    output ready);
endinterface

interface lrt_cfg_if import lrt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* design/lrt_cell.sv */
module lrt_cell import lrt_pkg::*; (
    input  logic            clk,
    input  cell_ctl_t       ctl,
    input  logic [ID_W-1:0] key,
    input  logic [ID_W-1:0] next_id,
    output logic [ID_W-1:0] id,
    output logic            match
);

    logic [ID_W-1:0] entry_reg;
    logic [ID_W-1:0] entry_next;

    // load the new entry, or take the younger neighbor's entry
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.take_key)
        begin
            entry_next = key;
        end
        else if (ctl.take_next)
        begin
            entry_next = next_id;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign id    = entry_reg;
    assign match = ctl.valid && (entry_reg == key);

endmodule

/* design/lru_residency_tracker.sv */
// Flow: an accepted word is looked up, a load into a full list then evicts from
//   the front one entry at a time, and the result is registered for the sink.
// A new word is taken only when idle or as the previous result is handed off;
//   the row shifts one position per cycle while evicting; a stalled result holds the block.
// Reset: clears the list length, counters and handshake state, sets the limit to 16;
//   no clearing pass, the block is ready as soon as reset is released.
module lru_residency_tracker import lrt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    lrt_cfg_if.sink   cfg,
    lrt_req_if.sink   req,
    lrt_rsp_if.source rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_EVICT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] max_resident_reg;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [TOT_W-1:0] hits_reg, hits_next;
    logic [TOT_W-1:0] misses_reg, misses_next;
    logic [TOT_W-1:0] evictions_reg, evictions_next;
    logic [ID_W-1:0]  key_reg, key_next;
    logic             cmd_reg, cmd_next;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] ev_cnt_reg, ev_cnt_next;
    logic [ID_W-1:0]  ev_id_reg, ev_id_next;
    logic             out_valid_reg, out_valid_next;

    logic [1:0]          out_status_reg;
    logic [CNT_W-1:0]    out_ev_cnt_reg;
    logic [ID_W-1:0]     out_ev_id_reg;
    logic [TOT_W-1:0]    out_hits_reg, out_misses_reg, out_evictions_reg;
    logic [CNT_W-1:0]    out_len_reg;

    cell_ctl_t        ctl [SLOTS];
    logic [ID_W-1:0]  cell_id [SLOTS];
    logic [ID_W-1:0]  cell_next [SLOTS];
    logic [SLOTS-1:0] match;
    logic             hit;
    logic [SLOT_W-1:0] pos;
    logic [CNT_W-1:0] lim;
    logic             slot_free;
    logic             accept;
    logic             load_out;
    logic             evict_append;

    // cell row
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        if (g == SLOTS - 1)
        begin : g_last
            assign cell_next[g] = ID_W'(0);
        end
        else
        begin : g_mid
            assign cell_next[g] = cell_id[g+1];
        end

        lrt_cell u_cell (
            .clk     (clk),
            .ctl     (ctl[g]),
            .key     (key_reg),
            .next_id (cell_next[g]),
            .id      (cell_id[g]),
            .match   (match[g])
        );
    end

    // clamp the limit to 1..SLOTS
    always_comb
    begin
        if (max_resident_reg == CNT_W'(0))
        begin
            lim = CNT_W'(1);
        end
        else if (max_resident_reg > CNT_W'(SLOTS))
        begin
            lim = CNT_W'(SLOTS);
        end
        else
        begin
            lim = max_resident_reg;
        end
    end

    // encode the matching cell; entries are unique
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (match[i])
            begin
                pos = pos | SLOT_W'(i);
            end
        end
    end

    assign hit          = |match;
    assign slot_free    = !out_valid_reg || rsp.ready;
    assign req.ready    = (state_reg == S_IDLE) || ((state_reg == S_DONE) && slot_free);
    assign accept       = req.valid && req.ready;
    assign load_out     = (state_reg == S_DONE) && slot_free;
    assign evict_append = (len_reg - CNT_W'(1)) < lim;
    assign cfg.ready    = 1'b1;

    // drive cell controls
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            ctl[i].valid     = CNT_W'(i) < len_reg;
            ctl[i].take_next = 1'b0;
            ctl[i].take_key  = 1'b0;
            if (state_reg == S_LOOK)
            begin
                if (hit && (cmd_reg == CMD_ACCESS))
                begin
                    ctl[i].take_next = (SLOT_W'(i) >= pos) && (CNT_W'(i) + CNT_W'(1) < len_reg);
                    ctl[i].take_key  = CNT_W'(i) + CNT_W'(1) == len_reg;
                end
                else if (!hit && (len_reg < lim))
                begin
                    ctl[i].take_key = CNT_W'(i) == len_reg;
                end
            end
            else if (state_reg == S_EVICT)
            begin
                ctl[i].take_next = CNT_W'(i) + CNT_W'(1) < len_reg;
                ctl[i].take_key  = evict_append && (CNT_W'(i) + CNT_W'(1) == len_reg);
            end
        end
    end

    // sequence one word: look up, evict from the front, then hand off the result
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        evictions_next = evictions_reg;
        key_next       = key_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        ev_cnt_next    = ev_cnt_reg;
        ev_id_next     = ev_id_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DONE;
                if (hit)
                begin
                    if (cmd_reg == CMD_ACCESS)
                    begin
                        status_next = ST_HIT;
                        if (hits_reg != TOT_MAX)
                        begin
                            hits_next = hits_reg + TOT_W'(1);
                        end
                    end
                    else
                    begin
                        status_next = ST_IGNORED;
                    end
                end
                else
                begin
                    if (cmd_reg == CMD_ACCESS)
                    begin
                        status_next = ST_MISS;
                        if (misses_reg != TOT_MAX)
                        begin
                            misses_next = misses_reg + TOT_W'(1);
                        end
                    end
                    else
                    begin
                        status_next = ST_PREFETCH;
                    end
                    if (len_reg < lim)
                    begin
                        len_next = len_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_next = S_EVICT;
                    end
                end
            end
            S_EVICT:
            begin
                ev_id_next  = cell_id[0];
                ev_cnt_next = ev_cnt_reg + CNT_W'(1);
                if (evictions_reg != TOT_MAX)
                begin
                    evictions_next = evictions_reg + TOT_W'(1);
                end
                if (evict_append)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    len_next = len_reg - CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
                else if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (accept)
        begin
            key_next    = {req.layer, req.expert};
            cmd_next    = req.command;
            ev_cnt_next = '0;
            ev_id_next  = '0;
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            max_resident_reg <= MAX_RESIDENT_RESET;
            len_reg          <= '0;
            hits_reg         <= '0;
            misses_reg       <= '0;
            evictions_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            evictions_reg <= evictions_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                max_resident_reg <= cfg.data;
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        ev_cnt_reg <= ev_cnt_next;
        ev_id_reg  <= ev_id_next;
    end

    // hold the result word for the sink
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg    <= status_reg;
            out_ev_cnt_reg    <= ev_cnt_reg;
            out_ev_id_reg     <= ev_id_reg;
            out_hits_reg      <= hits_reg;
            out_misses_reg    <= misses_reg;
            out_evictions_reg <= evictions_reg;
            out_len_reg       <= len_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.evicted_count  = out_ev_cnt_reg;
    assign rsp.evicted_layer  = out_ev_id_reg[ID_W-1:EXPERT_W];
    assign rsp.evicted_expert = out_ev_id_reg[EXPERT_W-1:0];
    assign rsp.hit_total      = out_hits_reg;
    assign rsp.miss_total     = out_misses_reg;
    assign rsp.eviction_total = out_evictions_reg;
    assign rsp.resident_count = out_len_reg;

endmodule

/* design/lrt_checker.sv */
module lrt_checker import lrt_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [1:0]          status,
    input logic [CNT_W-1:0]    evicted_count,
    input logic [LAYER_W-1:0]  evicted_layer,
    input logic [EXPERT_W-1:0] evicted_expert,
    input logic [CNT_W-1:0]    resident_count
);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(evicted_count) && $stable(resident_count))
        else $error("result word changed while stalled");

    // list never exceeds the slot count
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> resident_count <= CNT_W'(SLOTS))
        else $error("resident count above capacity");

    // hits and ignored prefetches evict nothing
    a_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_HIT || status == ST_IGNORED) |-> evicted_count == '0)
        else $error("eviction reported on a hit");

    // no eviction reports a zero victim
    a_zero_victim: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted_count == '0 |-> evicted_layer == '0 && evicted_expert == '0)
        else $error("victim reported without eviction");

    // a load leaves at least one entry resident
    a_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_MISS || status == ST_PREFETCH) |-> resident_count != '0)
        else $error("load left the list empty");

endmodule

bind lru_residency_tracker lrt_checker u_lrt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .evicted_count  (rsp.evicted_count),
    .evicted_layer  (rsp.evicted_layer),
    .evicted_expert (rsp.evicted_expert),
    .resident_count (rsp.resident_count)
);
